// ----- hdl/fifo_evicting_id_allowlist_assert.svh -----
// Assertion macros for the allowlist block.
`ifndef FIFO_EVICTING_ID_ALLOWLIST_ASSERT_SVH
`define FIFO_EVICTING_ID_ALLOWLIST_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define FEAL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FEAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FEAL_ASSERT(lbl, clk, rst_n, prop, msg)
`define FEAL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/feal_pkg.sv -----
`default_nettype none

package feal_pkg;

    localparam int LIST_DEPTH_DEF = 64;
    localparam int KEY_BYTES_DEF  = 8;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CHECK  = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    typedef struct packed {
        logic capture;
        logic fire;
        logic add_load;
        logic shift_all;
        logic shift_hit;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/feal_cell.sv -----
`default_nettype none

module feal_cell #(
    parameter int KEY_W = 64,
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  feal_pkg::cell_ctrl_t    ctrl,
    input  wire  [CNT_W-1:0]        cnt,
    input  wire  [KEY_W-1:0]        key,
    input  wire  [KEY_W-1:0]        neighbor_key,
    input  wire                     hit_in,
    output logic [KEY_W-1:0]        stored_key,
    output logic                    hit_out
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [KEY_W-1:0] key_reg;
    logic             match_reg;
    logic             live;

    assign live       = MY_IDX < cnt;
    assign hit_out    = hit_in | match_reg;
    assign stored_key = key_reg;

    // compare on capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            match_reg <= live && (key_reg == key);
        end
    end

    // shift toward the oldest end, or load the new key
    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            if (ctrl.shift_all || (ctrl.shift_hit && hit_out))
            begin
                key_reg <= neighbor_key;
            end
            else if (ctrl.add_load && (cnt == MY_IDX))
            begin
                key_reg <= key;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fifo_evicting_id_allowlist.sv -----
// An accepted input beat is compared across all cells as it is taken; the
// update that follows resolves the first match along the cell chain and
// registers the result. A new beat is not taken until that update is done.
// Reset: the list is empty after reset; stored keys are not cleared and are
// never read before they are written.
`default_nettype none

`include "fifo_evicting_id_allowlist_assert.svh"

module fifo_evicting_id_allowlist #(
    parameter int LIST_DEPTH = feal_pkg::LIST_DEPTH_DEF,
    parameter int KEY_BYTES  = feal_pkg::KEY_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  action,
    input  wire  [63:0] uid_key,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        found,
    output logic        evicted,
    output logic [6:0]  entry_total
);

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t               state_reg;
    logic [1:0]           act_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 out_valid_reg;
    logic                 found_reg;
    logic                 evicted_reg;

    logic                 in_beat;
    logic                 fire;
    logic                 full;
    logic                 any_hit;
    logic [KEY_W-1:0]     cell_key;
    feal_pkg::cell_ctrl_t ctrl;

    logic [KEY_W-1:0]     stored [LIST_DEPTH];
    logic [LIST_DEPTH:0]  hit_chain;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_beat     = in_valid && !in_stall;
    assign fire        = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign full        = (cnt_reg == FULL_CNT);
    assign any_hit     = hit_chain[LIST_DEPTH];
    assign cell_key    = in_beat ? uid_key[KEY_W-1:0] : key_reg;

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign evicted     = evicted_reg;
    assign entry_total = 7'(cnt_reg);

    always_comb
    begin
        ctrl.capture   = in_beat;
        ctrl.fire      = fire;
        ctrl.add_load  = (act_reg == feal_pkg::ACT_ADD) && !full;
        ctrl.shift_all = (act_reg == feal_pkg::ACT_ADD) && full;
        ctrl.shift_hit = (act_reg == feal_pkg::ACT_REMOVE);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        case (act_reg)
            feal_pkg::ACT_ADD:
            begin
                if (!full)
                begin
                    cnt_next = cnt_reg + ONE_CNT;
                end
            end
            feal_pkg::ACT_REMOVE:
            begin
                if (any_hit)
                begin
                    cnt_next = cnt_reg - ONE_CNT;
                end
            end
            feal_pkg::ACT_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] nb_key;
        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign nb_key = key_reg;
        end
        else
        begin : g_mid
            assign nb_key = stored[i+1];
        end

        feal_cell #(
            .KEY_W (KEY_W),
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .cnt          (cnt_reg),
            .key          (cell_key),
            .neighbor_key (nb_key),
            .hit_in       (hit_chain[i]),
            .stored_key   (stored[i]),
            .hit_out      (hit_chain[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            act_reg <= action;
            key_reg <= uid_key[KEY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            evicted_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (fire)
                    begin
                        state_reg <= S_IDLE;
                        cnt_reg   <= cnt_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                found_reg     <= any_hit && ((act_reg == feal_pkg::ACT_REMOVE)
                                          || (act_reg == feal_pkg::ACT_CHECK));
                evicted_reg   <= (act_reg == feal_pkg::ACT_ADD) && full;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `FEAL_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= FULL_CNT, "entry count above depth")
    `FEAL_ASSERT(a_evict_full, clk, rst_n, (out_valid_reg && evicted_reg) |-> full, "evict not full")
    `FEAL_ASSERT(a_found_evict, clk, rst_n, !(found_reg && evicted_reg), "found and evicted")
    `FEAL_ASSERT(a_beat_busy, clk, rst_n, in_beat |=> in_stall, "accepted beat did not start work")
    `FEAL_ASSERT_ALWAYS(a_fire_exec, clk, fire |-> (state_reg == S_EXEC), "update outside exec")

endmodule

`default_nettype wire
